>>> rtl/mact_pkg.sv
package mact_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int ACT_WIDTH = 25;
	localparam int QUO_WIDTH = 16;
	localparam int DIV_STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES = QUO_WIDTH / DIV_STEPS_PER_STAGE;

	typedef enum logic [2:0] {
		KIND_SIGMOID  = 3'd0,
		KIND_RELU     = 3'd1,
		KIND_LEAKY    = 3'd2,
		KIND_TANH     = 3'd3,
		KIND_GELU     = 3'd4,
		KIND_SOFTPLUS = 3'd5,
		KIND_SOFTSIGN = 3'd6,
		KIND_BAD      = 3'd7
	} kind_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] sample;
		logic signed [DATA_WIDTH-1:0] mask_value;
		logic                         last_item;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] result_value;
		logic                         last_out;
		logic                         bad_kind;
	} result_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] mask;
		logic                         last;
		logic                         bad;
		kind_t                        kind;
		logic                         neg;
		logic signed [ACT_WIDTH-1:0]  act;
	} meta_t;

	typedef struct packed {
		logic [16:0]          divisor;
		logic [16:0]          rem;
		logic [15:0]          num_lo;
		logic [QUO_WIDTH-1:0] quo;
	} div_t;

	typedef struct packed {
		meta_t meta;
		div_t  div;
	} lane_t;

	// Phi(x) in Q1.15 on [0,4], step 0.25.
	localparam logic [15:0] PHI_TABLE [0:16] = '{
		16'd16384, 16'd19618, 16'd22658, 16'd25342, 16'd27569, 16'd29306,
		16'd30579, 16'd31455, 16'd32023, 16'd32367, 16'd32565, 16'd32670,
		16'd32724, 16'd32749, 16'd32760, 16'd32765, 16'd32767
	};

	// ln(1 + exp(-x)) in Q.16 on [0,8], step 0.5.
	localparam logic [15:0] SOFTPLUS_TABLE [0:16] = '{
		16'd45426, 16'd31069, 16'd20530, 16'd13200, 16'd8318, 16'd5170,
		16'd3184, 16'd1950, 16'd1189, 16'd724, 16'd440, 16'd267,
		16'd162, 16'd98, 16'd60, 16'd36, 16'd22
	};

	// Piecewise-linear sigmoid of a magnitude (Q.8 in, Q.16 out).
	function automatic logic [16:0] sig_mag(input logic [16:0] s);
		logic [16:0] y;
		if (s >= 17'd1280) begin
			y = 17'd65536;
		end else if (s >= 17'd608) begin
			y = (s << 3) + 17'd55296;
		end else if (s >= 17'd256) begin
			y = (s << 5) + 17'd40960;
		end else begin
			y = (s << 6) + 17'd32768;
		end
		return y;
	endfunction

	// One restoring division step.
	function automatic div_t div_step(input div_t s);
		logic [17:0] r2;
		div_t n;
		n = s;
		r2 = {s.rem, s.num_lo[15]};
		if (r2 >= {1'b0, s.divisor}) begin
			n.rem = 17'(r2 - {1'b0, s.divisor});
			n.quo = {s.quo[QUO_WIDTH-2:0], 1'b1};
		end else begin
			n.rem = r2[16:0];
			n.quo = {s.quo[QUO_WIDTH-2:0], 1'b0};
		end
		n.num_lo = {s.num_lo[14:0], 1'b0};
		return n;
	endfunction

endpackage

>>> rtl/mact_act.sv
module mact_act (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  mact_pkg::sample_t in_data,
	input  mact_pkg::kind_t  kind,
	output logic             out_valid,
	output mact_pkg::lane_t  out_lane
);
	import mact_pkg::*;

	logic    valid_s1;
	sample_t smp_s1;
	kind_t   kind_s1;

	logic                        valid_s2;
	logic [15:0]                 a_s2;
	logic                        neg_s2;
	logic signed [DATA_WIDTH-1:0] mask_s2;
	logic                        last_s2;
	kind_t                       kind_s2;
	logic signed [ACT_WIDTH-1:0] act_s2;
	logic [15:0]                 p_s2;

	logic  valid_s3;
	lane_t lane_s3;

	logic        neg;
	logic [15:0] a;
	logic        pos;
	logic signed [ACT_WIDTH-1:0] x256;
	logic [16:0] sig;
	logic [16:0] sig_u;
	logic [16:0] y2;
	logic signed [ACT_WIDTH-1:0] t_pos;
	logic [25:0] lk_prod;
	logic [12:0] lk_mag;
	logic [4:0]  gi;
	logic [4:0]  gj;
	logic [6:0]  g_w;
	logic [22:0] g_sum;
	logic [15:0] p_pos;
	logic [15:0] p_val;
	logic [4:0]  si;
	logic [4:0]  sj;
	logic [7:0]  s_w;
	logic [23:0] s_sum;
	logic [15:0] sp_c;
	logic signed [ACT_WIDTH-1:0] act_pre;

	logic [32:0] g_prod;
	logic [25:0] g_mag;
	logic signed [ACT_WIDTH-1:0] act_fin;
	logic [16:0] divisor;

	always_comb begin
		neg = smp_s1.sample[DATA_WIDTH-1];
		a = neg ? 16'(-smp_s1.sample) : 16'(smp_s1.sample);
		pos = !neg && (a != 16'd0);
		x256 = $signed({1'b0, a, 8'd0});

		sig = sig_mag({1'b0, a});
		sig_u = neg ? 17'd65536 - sig : sig;

		// tanh(x) = 2 * sigmoid(2x) - 1
		y2 = sig_mag({a, 1'b0});
		t_pos = $signed({7'd0, y2, 1'b0}) - 25'sd65536;

		lk_prod = 26'(a) * 26'd524;
		lk_mag = 13'((lk_prod + 26'd2048) >> 12);

		gi = {1'b0, a[9:6]};
		gj = gi + 5'd1;
		g_w = 7'd64 - {1'b0, a[5:0]};
		g_sum = 23'(PHI_TABLE[gi]) * 23'(g_w) + 23'(PHI_TABLE[gj]) * 23'(a[5:0]) + 23'd32;
		p_pos = (a >= 16'd1024) ? 16'd32768 : 16'(g_sum >> 6);
		p_val = neg ? 16'd32768 - p_pos : p_pos;

		si = {1'b0, a[10:7]};
		sj = si + 5'd1;
		s_w = 8'd128 - {1'b0, a[6:0]};
		s_sum = 24'(SOFTPLUS_TABLE[si]) * 24'(s_w) + 24'(SOFTPLUS_TABLE[sj]) * 24'(a[6:0])
			+ 24'd64;
		sp_c = (a < 16'd2048) ? 16'(s_sum >> 7) : 16'd0;

		case (kind_s1)
			KIND_SIGMOID:  act_pre = $signed({8'd0, sig_u});
			KIND_RELU:     act_pre = pos ? x256 : '0;
			KIND_LEAKY:    act_pre = neg ? -$signed({12'd0, lk_mag}) : x256;
			KIND_TANH:     act_pre = neg ? -t_pos : t_pos;
			KIND_SOFTPLUS: act_pre = (pos ? x256 : '0) + $signed({9'd0, sp_c});
			default:       act_pre = '0;
		endcase
	end

	always_comb begin
		g_prod = 33'(a_s2) * 33'(p_s2) + 33'd64;
		g_mag = 26'(g_prod >> 7);
		if (kind_s2 == KIND_GELU) begin
			act_fin = neg_s2 ? -$signed(g_mag[ACT_WIDTH-1:0]) : $signed(g_mag[ACT_WIDTH-1:0]);
		end else begin
			act_fin = act_s2;
		end
		divisor = {1'b0, a_s2} + 17'd256;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s1 <= in_data;
			kind_s1 <= kind;

			a_s2 <= a;
			neg_s2 <= neg;
			mask_s2 <= smp_s1.mask_value;
			last_s2 <= smp_s1.last_item;
			kind_s2 <= kind_s1;
			act_s2 <= act_pre;
			p_s2 <= p_val;

			lane_s3.meta.mask <= mask_s2;
			lane_s3.meta.last <= last_s2;
			lane_s3.meta.bad <= (kind_s2 == KIND_BAD);
			lane_s3.meta.kind <= kind_s2;
			lane_s3.meta.neg <= neg_s2;
			lane_s3.meta.act <= act_fin;
			// Numerator is |x| * 65536 + divisor / 2; its high half is |x|.
			lane_s3.div.divisor <= divisor;
			lane_s3.div.rem <= {1'b0, a_s2};
			lane_s3.div.num_lo <= divisor[16:1];
			lane_s3.div.quo <= '0;
		end
	end

	assign out_valid = valid_s3;
	assign out_lane = lane_s3;

endmodule

>>> rtl/mact_div_stage.sv
module mact_div_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  mact_pkg::lane_t in_lane,
	output logic            out_valid,
	output mact_pkg::lane_t out_lane
);
	import mact_pkg::*;

	logic  valid_s1;
	lane_t lane_s1;
	div_t  steps [0:DIV_STEPS_PER_STAGE];

	always_comb begin
		steps[0] = in_lane.div;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			steps[i+1] = div_step(steps[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s1.meta <= in_lane.meta;
			lane_s1.div <= steps[DIV_STEPS_PER_STAGE];
		end
	end

	assign out_valid = valid_s1;
	assign out_lane = lane_s1;

endmodule

>>> rtl/mact_scale.sv
module mact_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  mact_pkg::lane_t   in_lane,
	output logic              out_valid,
	output mact_pkg::result_t out_data
);
	import mact_pkg::*;

	localparam logic [24:0] LIM_POS = 25'((2 ** (DATA_WIDTH - 1)) - 1);
	localparam logic [24:0] LIM_NEG = 25'(2 ** (DATA_WIDTH - 1));

	logic signed [ACT_WIDTH-1:0] act;
	logic                        act_neg;
	logic [23:0]                 am;
	logic [DATA_WIDTH-1:0]       mm;
	logic [39:0]                 prod;

	logic        valid_s1;
	logic [39:0] prod_s1;
	logic        neg_s1;
	logic        last_s1;
	logic        bad_s1;

	logic [40:0]           rnd;
	logic [24:0]           mag;
	logic [DATA_WIDTH-1:0] value;

	logic    valid_s2;
	result_t res_s2;

	always_comb begin
		if (in_lane.meta.kind == KIND_SOFTSIGN) begin
			act = in_lane.meta.neg ? -$signed({9'd0, in_lane.div.quo})
				: $signed({9'd0, in_lane.div.quo});
		end else begin
			act = in_lane.meta.act;
		end
		act_neg = act[ACT_WIDTH-1];
		am = act_neg ? 24'(-act) : 24'(act);
		mm = in_lane.meta.mask[DATA_WIDTH-1] ? DATA_WIDTH'(-in_lane.meta.mask)
			: DATA_WIDTH'(in_lane.meta.mask);
		prod = 40'(mm) * 40'(am);
	end

	always_comb begin
		rnd = 41'(prod_s1) + 41'd32768;
		mag = rnd[40:16];
		if (neg_s1) begin
			value = (mag >= LIM_NEG) ? DATA_WIDTH'(LIM_NEG) : DATA_WIDTH'(-mag[DATA_WIDTH-1:0]);
		end else begin
			value = (mag >= LIM_POS) ? DATA_WIDTH'(LIM_POS) : mag[DATA_WIDTH-1:0];
		end
		if (bad_s1) begin
			value = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod;
			neg_s1 <= in_lane.meta.mask[DATA_WIDTH-1] ^ act_neg;
			last_s1 <= in_lane.meta.last;
			bad_s1 <= in_lane.meta.bad;
			res_s2.result_value <= $signed(value);
			res_s2.last_out <= last_s1;
			res_s2.bad_kind <= bad_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = res_s2;

	// An unassigned kind always yields zero.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.bad_kind |-> res_s2.result_value == '0)
		else $error("bad kind gave nonzero result");

	// A zero product (zero mask or zero activation) rounds to exactly zero.
	a_zero_prod: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && prod_s1 == '0 |=> res_s2.result_value == '0)
		else $error("zero product gave nonzero result");

	// Saturation keeps the sign of a non-negative product: the result is never negative.
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && !neg_s1 |=> !res_s2.result_value[DATA_WIDTH-1])
		else $error("positive product gave negative result");

endmodule

>>> rtl/masked_activation_unit.sv
// Masked activation unit: one Q8.8 sample and one Q8.8 mask value per request,
// result = mask * act(sample), rounded and saturated to Q8.8.
//
// Channels: sample_valid/sample_stall carry sample_data; result_valid/result_stall
// carry result_data. A request moves when valid is high and stall is low.
// The cfg channel (cfg_valid/cfg_ready, always ready) writes the 3-bit
// activation kind; it should be written only while the pipeline is empty.
// A kind of 7 flags bad_kind and gives zero.
//
// An accepted sample reaches the output through these stages in order:
// three front stages (input, table lookup and interpolation, GeLU multiply),
// eight stages of a radix-2 restoring divider for softsign (two quotient bits
// per stage), and two stages for the mask multiply and saturation.
// Throughput is one request per cycle while result_stall does not hold the pipeline.
//
// Reset clears all valid bits and sets the kind to sigmoid. When result_stall
// is high with a result waiting, the whole pipeline holds and sample_stall is
// raised in the same cycle; nothing is lost or repeated.
module masked_activation_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  mact_pkg::sample_t sample_data,
	output logic              result_valid,
	input  logic              result_stall,
	output mact_pkg::result_t result_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_data
);
	import mact_pkg::*;

	kind_t kind_q;
	logic  adv;

	logic  lane_valid [0:DIV_STAGES];
	lane_t lane_data  [0:DIV_STAGES];

	assign cfg_ready = 1'b1;
	assign adv = !(result_valid && result_stall);
	assign sample_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_SIGMOID;
		end else if (cfg_valid && cfg_ready) begin
			kind_q <= kind_t'(cfg_data);
		end
	end

	mact_act u_act (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sample_valid),
		.in_data   (sample_data),
		.kind      (kind_q),
		.out_valid (lane_valid[0]),
		.out_lane  (lane_data[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		mact_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (lane_valid[g]),
			.in_lane   (lane_data[g]),
			.out_valid (lane_valid[g+1]),
			.out_lane  (lane_data[g+1])
		);
	end

	mact_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (lane_valid[DIV_STAGES]),
		.in_lane   (lane_data[DIV_STAGES]),
		.out_valid (result_valid),
		.out_data  (result_data)
	);

endmodule
